/* src/tfb_pkg.sv */
// Shared types and constants for the telemetry frame builder.
package tfb_pkg;

  localparam logic [7:0] FRAME_HEADER    = 8'hAA;
  localparam logic [7:0] PAYLOAD_LEN     = 8'd4;
  localparam logic [7:0] TARGET_ADDR_RST = 8'hFF;
  localparam logic [7:0] FUNCTION_ID_RST = 8'hF1;

  // Register indexes on the config port
  localparam logic REG_TARGET_ADDR = 1'b0;
  localparam logic REG_FUNCTION_ID = 1'b1;

  // Position of a byte inside the frame
  typedef logic [3:0] byte_idx_t;
  localparam byte_idx_t BYTE_HEADER = 4'd0;
  localparam byte_idx_t BYTE_TARGET = 4'd1;
  localparam byte_idx_t BYTE_FUNC   = 4'd2;
  localparam byte_idx_t BYTE_LEN    = 4'd3;
  localparam byte_idx_t BYTE_A_LO   = 4'd4;
  localparam byte_idx_t BYTE_A_HI   = 4'd5;
  localparam byte_idx_t BYTE_B_LO   = 4'd6;
  localparam byte_idx_t BYTE_B_HI   = 4'd7;
  localparam byte_idx_t BYTE_SUM    = 4'd8;
  localparam byte_idx_t BYTE_ADD    = 4'd9;

  // One frame request: payload plus the config snapshot taken at accept
  typedef struct packed {
    logic [15:0] value_a;
    logic [15:0] value_b;
    logic [7:0]  target_address;
    logic [7:0]  function_id;
  } frame_req_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

/* src/tfb_front.sv */
// Input stage: takes a beat, snapshots config, hands a request to the queue.
module tfb_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [31:0]        s_axis_tdata,   // [15:0] value_a, [31:16] value_b
  input  logic [7:0]         target_addr_i,
  input  logic [7:0]         function_id_i,
  output logic               req_valid_o,
  input  logic               req_ready_i,
  output tfb_pkg::frame_req_t req_o
);
  import tfb_pkg::*;

  logic       vld_q, vld_d;
  frame_req_t req_q;
  logic       take;

  assign s_axis_tready = !vld_q || req_ready_i;
  assign take          = s_axis_tvalid && s_axis_tready;

  always_comb begin
    vld_d = vld_q;
    if (take) begin
      vld_d = 1'b1;
    end else if (req_ready_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      req_q.value_a        <= s_axis_tdata[15:0];
      req_q.value_b        <= s_axis_tdata[31:16];
      req_q.target_address <= target_addr_i;
      req_q.function_id    <= function_id_i;
    end
  end

  assign req_valid_o = vld_q;
  assign req_o       = req_q;

endmodule

/* src/tfb_queue.sv */
// Small request FIFO between the front and back stages.
module tfb_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  tfb_pkg::frame_req_t push_data_i,
  output logic                push_ready_o,
  input  logic                pop_i,
  output tfb_pkg::frame_req_t head_o,
  output tfb_pkg::q_status_t  status_o
);
  import tfb_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  frame_req_t           mem_q [DEPTH];
  logic [PTR_W-1:0]     wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic                 do_push, do_pop;

  assign status_o.full  = (cnt_q == CNT_W'(DEPTH));
  assign status_o.empty = (cnt_q == '0);
  assign push_ready_o   = !status_o.full;
  assign do_push        = push_i && !status_o.full;
  assign do_pop         = pop_i && !status_o.empty;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign head_o = mem_q[rd_ptr_q];

endmodule

/* src/tfb_back.sv */
// Byte serializer: walks a request out as ten bytes with running checksums.
module tfb_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                head_valid_i,
  input  tfb_pkg::frame_req_t head_i,
  output logic                pop_o,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [7:0]          m_axis_tdata,   // [7:0] frame_byte
  output logic                m_axis_tlast    // last_byte
);
  import tfb_pkg::*;

  byte_idx_t  idx_q, idx_d;
  logic [7:0] sum_q, sum_d, add_q, add_d;
  logic [7:0] byte_val, sum_next;
  logic       vld_q, vld_d, last_q;
  logic [7:0] data_q;
  logic       adv, take, is_last;

  assign adv     = !vld_q || m_axis_tready;
  assign take    = adv && head_valid_i;
  assign is_last = (idx_q == BYTE_ADD);
  assign pop_o   = take && is_last;

  always_comb begin
    unique case (idx_q)
      BYTE_HEADER: byte_val = FRAME_HEADER;
      BYTE_TARGET: byte_val = head_i.target_address;
      BYTE_FUNC:   byte_val = head_i.function_id;
      BYTE_LEN:    byte_val = PAYLOAD_LEN;
      BYTE_A_LO:   byte_val = head_i.value_a[7:0];
      BYTE_A_HI:   byte_val = head_i.value_a[15:8];
      BYTE_B_LO:   byte_val = head_i.value_b[7:0];
      BYTE_B_HI:   byte_val = head_i.value_b[15:8];
      BYTE_SUM:    byte_val = sum_q;
      BYTE_ADD:    byte_val = add_q;
      default:     byte_val = '0;
    endcase
  end

  assign sum_next = sum_q + byte_val;

  always_comb begin
    idx_d = idx_q;
    sum_d = sum_q;
    add_d = add_q;
    vld_d = adv ? head_valid_i : vld_q;
    if (take) begin
      if (is_last) begin
        idx_d = BYTE_HEADER;
        sum_d = '0;
        add_d = '0;
      end else begin
        idx_d = idx_q + 1'b1;
        // checksums only cover the eight header and payload bytes
        if (idx_q < BYTE_SUM) begin
          sum_d = sum_next;
          add_d = add_q + sum_next;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q  <= BYTE_HEADER;
      sum_q  <= '0;
      add_q  <= '0;
      vld_q  <= 1'b0;
      last_q <= 1'b0;
    end else begin
      idx_q <= idx_d;
      sum_q <= sum_d;
      add_q <= add_d;
      vld_q <= vld_d;
      if (take) begin
        last_q <= is_last;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      data_q <= byte_val;
    end
  end

  assign m_axis_tvalid = vld_q;
  assign m_axis_tdata  = data_q;
  assign m_axis_tlast  = last_q;

endmodule

/* src/telemetry_frame_builder.sv */
// Top level of the telemetry frame builder: config registers, front, queue, back.
//
//  channel   dir  width  content
//  s_axis    in   32     [15:0] value_a, [31:16] value_b; one beat per frame
//  m_axis    out  8+1    tdata frame_byte, tlast on the add-check byte
//  cfg       in   1+8    index 0 target_address, index 1 function_id
//
// Each input beat becomes ten output beats, one per cycle while m_axis_tready
// is high; the back-end serializer sets the frame rate. The first byte is
// valid after the front register, queue write and output register.
// Input accepts while earlier frames drain, until the queue and front
// register are full. Reset clears all control; config returns to 0xFF/0xF1.
// Config is sampled into each request when the input beat is taken.
module telemetry_frame_builder #(
  parameter int unsigned QUEUE_DEPTH = 2  // requests buffered, 2..16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [15:0] value_a, [31:16] value_b
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] frame_byte
  output logic        m_axis_tlast    // last_byte
);
  import tfb_pkg::*;

  logic [7:0] target_addr_q, function_id_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_addr_q <= TARGET_ADDR_RST;
      function_id_q <= FUNCTION_ID_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_TARGET_ADDR: target_addr_q <= cfg_wdata_i;
        REG_FUNCTION_ID: function_id_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // front -> queue
  logic       req_valid, req_ready;
  frame_req_t req;
  // queue -> back
  frame_req_t head;
  q_status_t  q_stat;
  logic       pop;

  tfb_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .target_addr_i (target_addr_q),
    .function_id_i (function_id_q),
    .req_valid_o   (req_valid),
    .req_ready_i   (req_ready),
    .req_o         (req)
  );

  tfb_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (req_valid),
    .push_data_i  (req),
    .push_ready_o (req_ready),
    .pop_i        (pop),
    .head_o       (head),
    .status_o     (q_stat)
  );

  tfb_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_valid_i  (!q_stat.empty),
    .head_i        (head),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  // queue never popped while empty
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop |-> !q_stat.empty)
    else $error("pop from empty request queue");

  // a full queue holds off the front stage
  assert property (@(posedge clk_i) disable iff (!rst_ni) q_stat.full |-> !req_ready)
    else $error("queue full but front sees ready");

  // a frame pop always loads the last byte into the output register
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop |=> (m_axis_tvalid && m_axis_tlast))
    else $error("frame retired without tlast beat");

endmodule

/* dv/telemetry_frame_builder_tb.sv */
// Self-checking testbench for the telemetry frame builder.
`timescale 1ns / 100ps

module telemetry_frame_builder_tb;
  import tfb_pkg::*;

  localparam int DRAIN_CYCLES = 20;    // idle margin after every expected byte has drained
  localparam int HOLD_CYCLES  = 300;   // long receiver hold-off
  localparam int MAX_PRINTED  = 50;

  // One expected output beat
  typedef struct {
    logic [7:0] data;
    logic       last;
  } frame_beat_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_idx_i = 1'b0;
  logic [7:0]  cfg_wdata_i = 8'h00;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = 32'h0;   // [15:0] value_a, [31:16] value_b
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;           // [7:0] frame_byte
  logic        m_axis_tlast;

  // Shadow of the config registers, as the block should hold them
  logic [7:0]  shadow_target = TARGET_ADDR_RST;
  logic [7:0]  shadow_func   = FUNCTION_ID_RST;

  frame_beat_t expected_bytes_q[$];
  int          mismatches = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          holds_asked = 0;
  int          holds_served = 0;

  telemetry_frame_builder uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #5 clk_i = ~clk_i;

  task automatic flag_mismatch(input string msg);
    if (mismatches < MAX_PRINTED) $display("[%0t] mismatch: %s", $time, msg);
    mismatches++;
  endtask

  // Frame predictor: header, address, function, length, A lo/hi, B lo/hi,
  // then the running sum and the sum of running sums over those eight bytes.
  task automatic predict_frame(input logic [15:0] value_a, input logic [15:0] value_b);
    logic [7:0]  body[8];
    logic [7:0]  sum_chk;
    logic [7:0]  add_chk;
    frame_beat_t beat;
    sum_chk = 8'h00;
    add_chk = 8'h00;
    body[0] = FRAME_HEADER;
    body[1] = shadow_target;
    body[2] = shadow_func;
    body[3] = PAYLOAD_LEN;
    body[4] = value_a[7:0];
    body[5] = value_a[15:8];
    body[6] = value_b[7:0];
    body[7] = value_b[15:8];
    foreach (body[k]) begin
      sum_chk = sum_chk + body[k];
      add_chk = add_chk + sum_chk;
      beat.data = body[k];
      beat.last = 1'b0;
      expected_bytes_q.push_back(beat);
    end
    beat.data = sum_chk;
    beat.last = 1'b0;
    expected_bytes_q.push_back(beat);
    beat.data = add_chk;
    beat.last = 1'b1;
    expected_bytes_q.push_back(beat);
  endtask

  // Offer one pair of values; returns at the edge where the beat is taken.
  // tvalid stays high afterwards so back-to-back beats need no gap.
  task automatic send_values(input logic [15:0] value_a, input logic [15:0] value_b);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {value_b, value_a};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_frame(value_a, value_b);
  endtask

  // Drop tvalid, let every frame drain, then a margin for the pipeline
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (expected_bytes_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // One write strobe, then cfg_we_i held low so writes never share an edge
  task automatic write_reg(input logic idx, input logic [7:0] value);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_TARGET_ADDR) shadow_target = value;
    else                        shadow_func   = value;
    @(posedge clk_i);
  endtask

  // Random word biased toward the all-zero and all-one corners
  function automatic logic [15:0] pick_word();
    case ($urandom_range(7))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] pick_reg();
    case ($urandom_range(5))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // Reset values of both registers, payload corners
  task automatic test_reset_defaults();
    send_values(16'h0000, 16'h0000);
    send_values(16'hFFFF, 16'hFFFF);
    send_values(16'h0000, 16'hFFFF);
    send_values(16'hFFFF, 16'h0000);
    send_values(16'h00FF, 16'hFF00);
    send_values(16'hAAAA, 16'h5555);
    send_values(16'h1234, 16'hABCD);
    wait_idle();
  endtask

  // Both registers at their lowest and highest values
  task automatic test_config_extremes();
    write_reg(REG_TARGET_ADDR, 8'h00);
    write_reg(REG_FUNCTION_ID, 8'h00);
    send_values(16'h0000, 16'h0000);
    send_values(16'hFFFF, 16'hFFFF);
    send_values(16'h8001, 16'h7FFE);
    wait_idle();
    write_reg(REG_TARGET_ADDR, 8'hFF);
    write_reg(REG_FUNCTION_ID, 8'hFF);
    send_values(16'h0000, 16'h0000);
    send_values(16'hFFFF, 16'hFFFF);
    send_values(16'h5555, 16'hAAAA);
    wait_idle();
    write_reg(REG_TARGET_ADDR, 8'h00);
    write_reg(REG_FUNCTION_ID, 8'hFF);
    send_values(16'hFFFF, 16'h0001);
    send_values(16'h0100, 16'hFF7F);
    wait_idle();
  endtask

  // Receiver stops for a long stretch while the sender keeps pushing at
  // full rate: the internal queue fills and s_axis_tready must drop.
  task automatic test_output_stall();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    holds_asked++;
    repeat (8) send_values(pick_word(), pick_word());
    wait_idle();
  endtask

  // Random payloads in bursts, fresh register values between bursts
  task automatic test_random_frames(input int send_pct, input int recv_pct, input int count);
    int sent;
    sent = 0;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    while (sent < count) begin
      write_reg(REG_TARGET_ADDR, pick_reg());
      write_reg(REG_FUNCTION_ID, pick_reg());
      repeat (25) send_values(pick_word(), pick_word());
      sent += 25;
      wait_idle();
    end
  endtask

  // Receiver: random tready, or a long hold-off when one is requested
  initial begin : receiver
    int k;
    forever begin
      @(posedge clk_i);
      if (holds_served != holds_asked) begin
        holds_served++;
        for (k = 0; k < HOLD_CYCLES; k++) begin
          m_axis_tready <= 1'b0;
          @(posedge clk_i);
        end
      end
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Output checker: every accepted beat against the oldest expectation
  always @(posedge clk_i) begin
    frame_beat_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_bytes_q.size() == 0) begin
        flag_mismatch($sformatf("unexpected beat data %02h last %b",
                                m_axis_tdata, m_axis_tlast));
      end else begin
        want = expected_bytes_q.pop_front();
        if (m_axis_tdata !== want.data)
          flag_mismatch($sformatf("frame byte got %02h want %02h",
                                  m_axis_tdata, want.data));
        if (m_axis_tlast !== want.last)
          flag_mismatch($sformatf("tlast got %b want %b (byte %02h)",
                                  m_axis_tlast, want.last, want.data));
      end
    end
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_config_extremes();
    test_output_stall();
    test_random_frames(18, 82, 100);
    test_random_frames(82, 18, 100);
    test_random_frames(0, 0, 100);

    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest correct run
  initial begin
    #5_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
